FILE: hw/rtl/valve_response_diagnoser_macros.svh
// Assertion macros shared by the valve response diagnoser RTL.
`ifndef VALVE_RESPONSE_DIAGNOSER_MACROS_SVH
`define VALVE_RESPONSE_DIAGNOSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VRD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define VRD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/vrd_pkg.sv
// Types, codes and reset constants for the valve response diagnoser.
package vrd_pkg;

    typedef enum logic [1:0] {
        REQ_EVAL  = 2'd0,
        REQ_OPEN  = 2'd1,
        REQ_CLOSE = 2'd2
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE           = 3'd0,
        ST_WAIT_OPEN      = 3'd1,
        ST_WAIT_CLOSE     = 3'd2,
        ST_OPEN_OK        = 3'd3,
        ST_SENSOR_MISSING = 3'd4,
        ST_STUCK_CLOSED   = 3'd5,
        ST_NO_RESPONSE    = 3'd6,
        ST_STUCK_OPEN     = 3'd7
    } status_t;

    localparam logic [1:0] CFG_OPEN_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_CLOSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MIN_FLOW      = 2'd2;
    localparam logic [1:0] CFG_MIN_PRESSURE  = 2'd3;

    localparam logic [31:0] OPEN_TIMEOUT_RST  = 32'd30000;
    localparam logic [31:0] CLOSE_TIMEOUT_RST = 32'd30000;
    localparam logic [15:0] MIN_FLOW_RST      = 16'd100;
    localparam logic [15:0] MIN_PRESSURE_RST  = 16'd200;

    typedef struct packed {
        logic [31:0] open_timeout_ms;
        logic [31:0] close_timeout_ms;
        logic [15:0] min_flow_centi_lpm;
        logic [15:0] min_pressure_mbar;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  zone_number;
        logic [31:0] time_ms;
        logic        flow_ok;
        logic [15:0] flow_centi_lpm;
        logic        pressure_ok;
        logic [15:0] pressure_reading;
    } item_t;

    typedef struct packed {
        status_t     diag_status;
        logic        shutdown_needed;
        logic [7:0]  current_zone;
    } result_t;

    function automatic logic is_shutdown(status_t st);
        return (st == ST_STUCK_CLOSED) || (st == ST_NO_RESPONSE) || (st == ST_STUCK_OPEN);
    endfunction

endpackage

FILE: hw/rtl/vrd_cfg_regs.sv
// Configuration register file: timeouts and sensor thresholds.
module vrd_cfg_regs (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    output vrd_pkg::cfg_t cfg
);
    import vrd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_OPEN_TIMEOUT:  cfg_next.open_timeout_ms    = cfg_wdata;
                CFG_CLOSE_TIMEOUT: cfg_next.close_timeout_ms   = cfg_wdata;
                CFG_MIN_FLOW:      cfg_next.min_flow_centi_lpm = cfg_wdata[15:0];
                CFG_MIN_PRESSURE:  cfg_next.min_pressure_mbar  = cfg_wdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_timeout_ms    <= OPEN_TIMEOUT_RST;
            cfg_reg.close_timeout_ms   <= CLOSE_TIMEOUT_RST;
            cfg_reg.min_flow_centi_lpm <= MIN_FLOW_RST;
            cfg_reg.min_pressure_mbar  <= MIN_PRESSURE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/vrd_core.sv
// Diagnosis state registers and the single-pass next-state logic.
module vrd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  vrd_pkg::item_t   item,
    input  vrd_pkg::cfg_t    cfg,
    output vrd_pkg::result_t result
);
    import vrd_pkg::*;

    status_t     status_reg,     status_next;
    logic [31:0] start_time_reg, start_time_next;
    logic [7:0]  zone_reg,       zone_next;
    logic        open_cmd_reg,   open_cmd_next;

    logic        flow_detected;
    logic        supply;
    logic [31:0] elapsed;
    logic        open_expired;
    logic        close_expired;
    status_t     failed_open;

    always_comb begin
        flow_detected = item.flow_ok && (item.flow_centi_lpm >= cfg.min_flow_centi_lpm);
        supply        = item.pressure_ok && (item.pressure_reading >= cfg.min_pressure_mbar);
        elapsed       = item.time_ms - start_time_reg;   // modulo 2^32
        open_expired  = elapsed >= cfg.open_timeout_ms;
        close_expired = elapsed >= cfg.close_timeout_ms;
        failed_open   = supply ? ST_STUCK_CLOSED : ST_NO_RESPONSE;

        status_next     = status_reg;
        start_time_next = start_time_reg;
        zone_next       = zone_reg;
        open_cmd_next   = open_cmd_reg;

        unique case (item.req_type)
            REQ_EVAL: begin
                unique case (status_reg)
                    ST_WAIT_OPEN: begin
                        if (flow_detected) begin
                            status_next = ST_OPEN_OK;
                        end else if (open_expired) begin
                            status_next = item.flow_ok ? failed_open : ST_SENSOR_MISSING;
                        end
                    end
                    ST_WAIT_CLOSE: begin
                        if (item.flow_ok && !flow_detected) begin
                            status_next = ST_IDLE;
                            zone_next   = '0;
                        end else if (close_expired) begin
                            status_next = item.flow_ok ? ST_STUCK_OPEN : ST_SENSOR_MISSING;
                        end
                    end
                    ST_IDLE: begin
                        // unexpected flow with no valve commanded
                        if (flow_detected) begin
                            status_next     = ST_WAIT_CLOSE;
                            start_time_next = item.time_ms;
                        end
                    end
                    ST_SENSOR_MISSING: begin
                        if (item.flow_ok) begin
                            if (open_cmd_reg) begin
                                status_next = flow_detected ? ST_OPEN_OK : failed_open;
                            end else if (flow_detected) begin
                                status_next = ST_STUCK_OPEN;
                            end else begin
                                status_next = ST_IDLE;
                                zone_next   = '0;
                            end
                        end
                    end
                    ST_OPEN_OK, ST_STUCK_CLOSED, ST_NO_RESPONSE, ST_STUCK_OPEN: begin
                        status_next = status_reg;   // held until a command
                    end
                    default: status_next = status_reg;
                endcase
            end
            REQ_OPEN: begin
                if (item.zone_number != '0) begin
                    status_next     = ST_WAIT_OPEN;
                    start_time_next = item.time_ms;
                    zone_next       = item.zone_number;
                    open_cmd_next   = 1'b1;
                end
            end
            REQ_CLOSE: begin
                status_next     = ST_WAIT_CLOSE;
                start_time_next = item.time_ms;
                open_cmd_next   = 1'b0;
            end
            default: status_next = status_reg;  // unused code leaves state alone
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= ST_IDLE;
            start_time_reg <= '0;
            zone_reg       <= '0;
            open_cmd_reg   <= 1'b0;
        end else if (advance) begin
            status_reg     <= status_next;
            start_time_reg <= start_time_next;
            zone_reg       <= zone_next;
            open_cmd_reg   <= open_cmd_next;
        end
    end

    assign result.diag_status     = status_next;
    assign result.shutdown_needed = is_shutdown(status_next);
    assign result.current_zone    = zone_next;

endmodule

FILE: hw/rtl/valve_response_diagnoser.sv
// Top level of the valve response diagnoser: input and result registers around the core.
//
//   channel   direction   handshake          payload
//   s_*       in          s_valid/s_ready    request, zone, time, flow and pressure readings
//   m_*       out         m_valid/m_ready    diag_status, shutdown_needed, current_zone
//   cfg_*     in          cfg_we             cfg_addr selects register, cfg_wdata
//
// One transaction per cycle sustained. An accepted item sits in the input register until the
// result slot is free, then its result is loaded into the result register while the state
// updates, and m_valid rises. Throughput is set by the single state update per item.
// Synchronous active-low reset clears state and both valid flags and loads config defaults.
// A stall on m_ready holds the result; the input register then fills and s_ready drops.
module valve_response_diagnoser (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_zone_number,
    input  logic [31:0] s_time_ms,
    input  logic        s_flow_ok,
    input  logic [15:0] s_flow_centi_lpm,
    input  logic        s_pressure_ok,
    input  logic [15:0] s_pressure_reading,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_diag_status,
    output logic        m_shutdown_needed,
    output logic [7:0]  m_current_zone
);
    import vrd_pkg::*;
    `include "valve_response_diagnoser_macros.svh"

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    result_t core_result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_fire;
    logic    shdn_ok;
    logic    idle_ok;
    logic    wait_open_ok;

    // The item in the input register moves on whenever the result slot is free
    // or is being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    vrd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    vrd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.req_type         <= s_req_type;
            in_item_reg.zone_number      <= s_zone_number;
            in_item_reg.time_ms          <= s_time_ms;
            in_item_reg.flow_ok          <= s_flow_ok;
            in_item_reg.flow_centi_lpm   <= s_flow_centi_lpm;
            in_item_reg.pressure_ok      <= s_pressure_ok;
            in_item_reg.pressure_reading <= s_pressure_reading;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_diag_status     = out_reg.diag_status;
    assign m_shutdown_needed = out_reg.shutdown_needed;
    assign m_current_zone    = out_reg.current_zone;

    // consistency terms on the result port
    assign shdn_ok      = m_shutdown_needed == is_shutdown(status_t'(m_diag_status));
    assign idle_ok      = (m_diag_status != ST_IDLE) || (m_current_zone == 8'd0);
    assign wait_open_ok = (m_diag_status != ST_WAIT_OPEN) || (m_current_zone != 8'd0);

    // Shutdown flag must track the three fault verdicts.
    `VRD_ASSERT_NOW(a_shutdown_flag, aclk, aresetn, m_valid, shdn_ok, "shutdown flag off status")
    // Idle is only reached with the zone cleared.
    `VRD_ASSERT_NOW(a_idle_no_zone, aclk, aresetn, m_valid, idle_ok, "idle with a zone active")
    // Waiting on an open needs a real zone.
    `VRD_ASSERT_NOW(a_wait_open_zone, aclk, aresetn, m_valid, wait_open_ok, "wait open, zone 0")
    // A transaction that moves through the core always lands in the result register.
    `VRD_ASSERT_NEXT(a_advance_lands, aclk, aresetn, advance, m_valid, "advanced item lost")
    // A held input item is never dropped.
    `VRD_ASSERT_NEXT(a_hold_input, aclk, aresetn, in_valid_reg && !advance, in_valid_reg, "input lost")

endmodule

FILE: tb/sv/vrd_checker.sv
// Checker for the valve response diagnoser: watches both channels, predicts and compares.
module vrd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_zone_number,
    input  logic [31:0] s_time_ms,
    input  logic        s_flow_ok,
    input  logic [15:0] s_flow_centi_lpm,
    input  logic        s_pressure_ok,
    input  logic [15:0] s_pressure_reading,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_diag_status,
    input  logic        m_shutdown_needed,
    input  logic [7:0]  m_current_zone,
    output int          mismatch_count,
    output int          pending_results
);
    import vrd_pkg::*;

    cfg_t        cfg_copy;
    status_t     valve_status;
    logic [31:0] phase_start_ms;
    logic [7:0]  open_zone;
    logic        opening;
    result_t     expected_results[$];
    int          failures = 0;

    function automatic status_t open_failure(input logic supply_seen);
        return supply_seen ? ST_STUCK_CLOSED : ST_NO_RESPONSE;
    endfunction

    // Applies one request to the valve state and returns the status it reports.
    task automatic diagnose_request(input item_t it, output result_t res);
        logic        flow_seen;
        logic        supply_seen;
        logic [31:0] elapsed;
        flow_seen   = it.flow_ok && (it.flow_centi_lpm >= cfg_copy.min_flow_centi_lpm);
        supply_seen = it.pressure_ok && (it.pressure_reading >= cfg_copy.min_pressure_mbar);
        elapsed     = it.time_ms - phase_start_ms;
        case (it.req_type)
            REQ_EVAL: begin
                case (valve_status)
                    ST_WAIT_OPEN: begin
                        if (flow_seen)
                            valve_status = ST_OPEN_OK;
                        else if (elapsed >= cfg_copy.open_timeout_ms)
                            valve_status = it.flow_ok ? open_failure(supply_seen)
                                                      : ST_SENSOR_MISSING;
                    end
                    ST_WAIT_CLOSE: begin
                        if (it.flow_ok && !flow_seen) begin
                            valve_status = ST_IDLE;
                            open_zone    = 8'd0;
                        end else if (elapsed >= cfg_copy.close_timeout_ms) begin
                            valve_status = it.flow_ok ? ST_STUCK_OPEN : ST_SENSOR_MISSING;
                        end
                    end
                    ST_IDLE: begin
                        if (flow_seen) begin
                            valve_status   = ST_WAIT_CLOSE;
                            phase_start_ms = it.time_ms;
                        end
                    end
                    ST_SENSOR_MISSING: begin
                        if (it.flow_ok) begin
                            if (opening) begin
                                valve_status = flow_seen ? ST_OPEN_OK : open_failure(supply_seen);
                            end else if (flow_seen) begin
                                valve_status = ST_STUCK_OPEN;
                            end else begin
                                valve_status = ST_IDLE;
                                open_zone    = 8'd0;
                            end
                        end
                    end
                    default: ;  // verdicts hold until a command
                endcase
            end
            REQ_OPEN: begin
                if (it.zone_number != 8'd0) begin
                    valve_status   = ST_WAIT_OPEN;
                    phase_start_ms = it.time_ms;
                    open_zone      = it.zone_number;
                    opening        = 1'b1;
                end
            end
            REQ_CLOSE: begin
                valve_status   = ST_WAIT_CLOSE;
                phase_start_ms = it.time_ms;
                opening        = 1'b0;
            end
            default: ;
        endcase
        res.diag_status     = valve_status;
        res.shutdown_needed = valve_status inside {ST_STUCK_CLOSED, ST_NO_RESPONSE, ST_STUCK_OPEN};
        res.current_zone    = open_zone;
    endtask

    always @(posedge aclk) begin
        item_t   req;
        result_t want;
        if (!aresetn) begin
            cfg_copy       = '{OPEN_TIMEOUT_RST, CLOSE_TIMEOUT_RST, MIN_FLOW_RST, MIN_PRESSURE_RST};
            valve_status   = ST_IDLE;
            phase_start_ms = '0;
            open_zone      = '0;
            opening        = 1'b0;
            expected_results.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_OPEN_TIMEOUT:  cfg_copy.open_timeout_ms    = cfg_wdata;
                    CFG_CLOSE_TIMEOUT: cfg_copy.close_timeout_ms   = cfg_wdata;
                    CFG_MIN_FLOW:      cfg_copy.min_flow_centi_lpm = cfg_wdata[15:0];
                    CFG_MIN_PRESSURE:  cfg_copy.min_pressure_mbar  = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                req = '{s_req_type, s_zone_number, s_time_ms, s_flow_ok, s_flow_centi_lpm,
                        s_pressure_ok, s_pressure_reading};
                diagnose_request(req, want);
                expected_results.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (failures < 10)
                        $display("unexpected result: status %0d shutdown %0b zone %0d",
                                 m_diag_status, m_shutdown_needed, m_current_zone);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_diag_status !== want.diag_status ||
                        m_shutdown_needed !== want.shutdown_needed ||
                        m_current_zone !== want.current_zone) begin
                        if (failures < 10) begin
                            $write("result mismatch: expected status %0d shutdown %0b zone %0d, ",
                                   want.diag_status, want.shutdown_needed, want.current_zone);
                            $display("got status %0d shutdown %0b zone %0d",
                                     m_diag_status, m_shutdown_needed, m_current_zone);
                        end
                        failures++;
                    end
                end
            end
        end
        mismatch_count  <= failures;
        pending_results <= expected_results.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
// Testbench top for the valve response diagnoser: stimulus, flow control and verdict.
module tb_top;
    import vrd_pkg::*;

    // The fourth request encoding is unused by the block and must leave it untouched.
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 70;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_addr  = CFG_OPEN_TIMEOUT;
    logic [31:0] cfg_wdata = '0;

    logic        s_valid            = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type         = REQ_EVAL;
    logic [7:0]  s_zone_number      = '0;
    logic [31:0] s_time_ms          = '0;
    logic        s_flow_ok          = 1'b0;
    logic [15:0] s_flow_centi_lpm   = '0;
    logic        s_pressure_ok      = 1'b0;
    logic [15:0] s_pressure_reading = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_diag_status;
    logic        m_shutdown_needed;
    logic [7:0]  m_current_zone;

    int          mismatch_count;
    int          pending_results;

    // Stimulus-side view of the settings, used to aim timestamps and readings.
    cfg_t        cur_cfg;
    logic [31:0] now_ms  = '0;
    logic [31:0] mark_ms = '0;  // time of the most recent command
    bit          throttle = 1'b0;
    int          rx_stall = 0;
    int          idle_cycles = 0;

    valve_response_diagnoser u_top (.*);
    vrd_checker u_checker (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mostly no gap, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side back-pressure; new stalls start only while throttling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else if (throttle && $urandom_range(0, 3) == 0) begin
            m_ready  <= 1'b0;
            rx_stall <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: any stretch without a transaction on either channel this long is a hang.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    // One request transaction. Valid stays high across back-to-back items, so this task only
    // drops it when a gap is actually inserted.
    task automatic send_item(input logic [1:0] req, input logic [7:0] zone,
                             input logic [31:0] stamp, input logic fok,
                             input logic [15:0] flow, input logic pok,
                             input logic [15:0] pres);
        int gap;
        gap = throttle ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_req_type         <= req;
        s_zone_number      <= zone;
        s_time_ms          <= stamp;
        s_flow_ok          <= fok;
        s_flow_centi_lpm   <= flow;
        s_pressure_ok      <= pok;
        s_pressure_reading <= pres;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic eval_at(input logic [31:0] stamp, input logic fok, input logic [15:0] flow,
                           input logic pok, input logic [15:0] pres);
        send_item(REQ_EVAL, 8'd0, stamp, fok, flow, pok, pres);
    endtask

    // Stop sending and wait until every predicted result has been delivered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all four registers on consecutive cycles; the block is idle here.
    task automatic program_config(input cfg_t c);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_OPEN_TIMEOUT;
        cfg_wdata <= c.open_timeout_ms;
        @(posedge aclk);
        cfg_addr  <= CFG_CLOSE_TIMEOUT;
        cfg_wdata <= c.close_timeout_ms;
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_FLOW;
        cfg_wdata <= {16'd0, c.min_flow_centi_lpm};
        @(posedge aclk);
        cfg_addr  <= CFG_MIN_PRESSURE;
        cfg_wdata <= {16'd0, c.min_pressure_mbar};
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_cfg = c;
    endtask

    // Readings clustered around a threshold, with full-range values and the rails mixed in.
    function automatic logic [15:0] near_level(input logic [15:0] thr);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
            v = int'(thr) + int'($urandom_range(0, 2)) - 1;
        else if (r < 7)
            v = $urandom_range(0, 65535);
        else if (r == 7)
            v = 0;
        else if (r == 8)
            v = 65535;
        else
            v = int'(thr) + ($urandom_range(0, 1) ? 50 : -50);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Next timestamp: mostly forward steps scaled to the timeout, plus hits right on and
    // just short of the timeout, repeats, backward steps and arbitrary jumps.
    function automatic logic [31:0] next_stamp();
        logic [31:0] tmo;
        logic [31:0] span;
        int          r;
        tmo  = $urandom_range(0, 1) ? cur_cfg.open_timeout_ms : cur_cfg.close_timeout_ms;
        span = tmo >> 2;
        if (span > 32'd100000)
            span = 32'd100000;
        r = $urandom_range(0, 19);
        if (r < 9)
            return now_ms + $urandom_range(0, span);
        if (r < 11)
            return mark_ms + tmo;
        if (r == 11)
            return mark_ms + tmo - 32'd1;
        if (r == 12)
            return mark_ms - 32'd1;
        if (r == 13)
            return now_ms;
        if (r == 14)
            return now_ms - $urandom_range(1, 1000);
        if (r < 17)
            return $urandom();
        return now_ms + (tmo >> 1);
    endfunction

    // Opens, closes and unused codes mixed with runs of evaluations; commands carry junk readings.
    task automatic random_item();
        int         r;
        logic [7:0] zone;
        r = $urandom_range(0, 99);
        now_ms = next_stamp();
        if (r < 14) begin
            zone = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            mark_ms = now_ms;
            send_item(REQ_OPEN, zone, now_ms, 1'($urandom()), 16'($urandom()),
                      1'($urandom()), 16'($urandom()));
        end else if (r < 25) begin
            mark_ms = now_ms;
            send_item(REQ_CLOSE, 8'($urandom()), now_ms, 1'($urandom()), 16'($urandom()),
                      1'($urandom()), 16'($urandom()));
        end else if (r < 28) begin
            send_item(REQ_UNUSED, 8'($urandom()), now_ms, 1'($urandom()), 16'($urandom()),
                      1'($urandom()), 16'($urandom()));
        end else begin
            send_item(REQ_EVAL, 8'($urandom()), now_ms, $urandom_range(0, 9) != 0,
                      near_level(cur_cfg.min_flow_centi_lpm), $urandom_range(0, 7) != 0,
                      near_level(cur_cfg.min_pressure_mbar));
        end
    endtask

    initial begin
        cfg_t plan[6];

        cur_cfg = '{OPEN_TIMEOUT_RST, CLOSE_TIMEOUT_RST, MIN_FLOW_RST, MIN_PRESSURE_RST};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass at the reset settings: 30 s timeouts, flow 1.00 l/min, 200 mbar.
        eval_at(32'd0, 1'b1, 16'd99, 1'b1, 16'd0);                 // idle, flow just below
        send_item(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
        send_item(REQ_OPEN, 8'd0, 32'd500, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF);  // zone 0 ignored
        eval_at(32'd1000, 1'b1, 16'd100, 1'b0, 16'd0);            // idle with flow: wait close
        eval_at(32'd30999, 1'b0, 16'd0, 1'b0, 16'd0);             // one ms short of timeout
        eval_at(32'd31000, 1'b0, 16'd0, 1'b0, 16'd0);             // sensor missing
        eval_at(32'd31001, 1'b1, 16'hFFFF, 1'b0, 16'd0);          // recovers to stuck open
        eval_at(32'd40000, 1'b1, 16'd0, 1'b1, 16'd500);           // verdict holds
        send_item(REQ_OPEN, 8'hFF, 32'hFFFF_FF00, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'h0000_0074, 1'b1, 16'd99, 1'b1, 16'd200);      // wrapped, short elapsed
        eval_at(32'hFFFF_FF00 + 32'd30000, 1'b1, 16'd0, 1'b1, 16'hFFFF);  // stuck closed
        send_item(REQ_OPEN, 8'd1, 32'd100000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd130000, 1'b1, 16'd50, 1'b1, 16'd199);         // no supply: no response
        send_item(REQ_OPEN, 8'h80, 32'd200000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd200001, 1'b1, 16'd100, 1'b1, 16'd200);        // open confirmed
        eval_at(32'd300000, 1'b0, 16'd0, 1'b0, 16'd0);
        send_item(REQ_CLOSE, 8'd0, 32'd300000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd300001, 1'b1, 16'd99, 1'b0, 16'd0);           // flow gone: idle
        send_item(REQ_OPEN, 8'h55, 32'd400000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd430000, 1'b0, 16'd0, 1'b1, 16'd300);          // missing while opening
        eval_at(32'd430001, 1'b1, 16'd100, 1'b1, 16'd300);        // recovers to open ok
        send_item(REQ_OPEN, 8'h2A, 32'd500000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd530000, 1'b0, 16'd0, 1'b1, 16'hFFFF);
        eval_at(32'd530001, 1'b1, 16'd10, 1'b0, 16'hFFFF);        // invalid pressure reading
        send_item(REQ_CLOSE, 8'd0, 32'd600000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd630000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd630001, 1'b1, 16'd0, 1'b0, 16'd0);            // missing recovers to idle
        send_item(REQ_CLOSE, 8'd0, 32'd700000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd730000, 1'b1, 16'd500, 1'b0, 16'd0);          // still flowing: stuck open
        send_item(REQ_OPEN, 8'd3, 32'd800000, 1'b0, 16'd0, 1'b0, 16'd0);
        eval_at(32'd799999, 1'b1, 16'd0, 1'b1, 16'd500);          // time went backward
        now_ms  = 32'd800000;
        mark_ms = now_ms;

        // Settings per random phase: both rails, zero timeouts, then a few moderate ones.
        plan[0] = '{32'd1, 32'd1, 16'd0, 16'd0};
        plan[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF};
        plan[2] = '{32'd0, 32'd0, 16'd100, 16'd200};
        for (int p = 3; p < 6; p++)
            plan[p] = '{32'($urandom_range(1, 5000)), 32'($urandom_range(1, 5000)),
                        16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000))};

        for (int p = 0; p < 6; p++) begin
            wait_drained();
            program_config(plan[p]);
            throttle = (p % 3 != 0);
            repeat (PHASE_ITEMS) random_item();
        end

        wait_drained();
        if (mismatch_count == 0 && pending_results == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/vrd_pkg.sv
hw/rtl/vrd_cfg_regs.sv
hw/rtl/vrd_core.sv
hw/rtl/valve_response_diagnoser.sv
tb/sv/vrd_checker.sv
tb/sv/tb_top.sv
